@@ design/uds_pkg.sv @@
// Shared types, constants and byte classification helpers for the UTF-8 display sanitizer.
// No dependencies; every other design file refers to it by scoped names.
package uds_pkg;

  localparam int unsigned BundleBytes = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned AddrWidth = 3;

  localparam logic [7:0] ReplReset = 8'h20;

  localparam logic [0:0] RegReplacement = 1'b0;

  localparam logic [7:0] CtrlLimit = 8'h20;
  localparam logic [7:0] DelByte = 8'h7F;
  localparam logic [7:0] C1Lead = 8'hC2;
  localparam logic [7:0] ContLow = 8'h80;
  localparam logic [7:0] C1High = 8'h9F;
  localparam logic [7:0] ContHigh = 8'hBF;
  localparam logic [7:0] Lead2High = 8'hDF;
  localparam logic [7:0] Lead3Low = 8'hE0;
  localparam logic [7:0] Lead3High = 8'hEF;
  localparam logic [7:0] Lead4Low = 8'hF0;
  localparam logic [7:0] Lead4High = 8'hF4;

  typedef struct packed {
    logic [BundleBytes-1:0][7:0] data;
    logic [1:0]                  last_idx;
    logic                        text_end;
  } bundle_t;

  function automatic logic is_ctrl(input logic [7:0] b);
    return (b < CtrlLimit) || (b == DelByte);
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b >= ContLow) && (b <= ContHigh);
  endfunction

  function automatic logic is_c1(input logic [7:0] b);
    return (b >= ContLow) && (b <= C1High);
  endfunction

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if ((b >= C1Lead) && (b <= Lead2High)) len = 3'd2;
    else if ((b >= Lead3Low) && (b <= Lead3High)) len = 3'd3;
    else if ((b >= Lead4Low) && (b <= Lead4High)) len = 3'd4;
    return len;
  endfunction

  function automatic logic [7:0] rescan(input logic [7:0] b, input logic [7:0] repl);
    return is_c1(b) ? repl : b;
  endfunction

endpackage

@@ design/uds_front.sv @@
// Front end: accepts text bytes, tracks the pending multi-byte sequence and
// builds a bundle of up to four output bytes per input. Depends on uds_pkg.
module uds_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  input  logic [7:0]         repl_i,
  output logic               bundle_vld_o,
  output uds_pkg::bundle_t   bundle_o
);

  logic [7:0] lead_q, lead_d;
  logic [7:0] held_q [2];
  logic [7:0] held_d [2];
  logic [1:0] hcnt_q, hcnt_d;
  logic [2:0] elen_q, elen_d;

  logic [7:0] obuf [uds_pkg::BundleBytes];
  logic [2:0] n;
  logic       pending;
  logic       fresh;
  logic [2:0] blen;

  always_comb begin
    lead_d    = lead_q;
    held_d[0] = held_q[0];
    held_d[1] = held_q[1];
    hcnt_d    = hcnt_q;
    elen_d    = elen_q;
    for (int k = 0; k < uds_pkg::BundleBytes; k++) obuf[k] = 8'h00;
    n       = 3'd0;
    fresh   = 1'b0;
    pending = (elen_q != 3'd0);
    blen    = uds_pkg::seq_len(in_byte_i);

    if (pending) begin
      if ((lead_q == uds_pkg::C1Lead) && (hcnt_q == 2'd0) && uds_pkg::is_c1(in_byte_i)) begin
        obuf[n[1:0]] = repl_i;
        n = n + 3'd1;
        lead_d = 8'h00;
        hcnt_d = 2'd0;
        elen_d = 3'd0;
      end else if (uds_pkg::is_cont(in_byte_i)) begin
        if (({1'b0, hcnt_q} + 3'd2) >= elen_q) begin
          obuf[n[1:0]] = lead_q;
          n = n + 3'd1;
          if (hcnt_q >= 2'd1) begin
            obuf[n[1:0]] = held_q[0];
            n = n + 3'd1;
          end
          if (hcnt_q >= 2'd2) begin
            obuf[n[1:0]] = held_q[1];
            n = n + 3'd1;
          end
          obuf[n[1:0]] = in_byte_i;
          n = n + 3'd1;
          lead_d = 8'h00;
          hcnt_d = 2'd0;
          elen_d = 3'd0;
        end else begin
          held_d[hcnt_q[0]] = in_byte_i;
          hcnt_d = hcnt_q + 2'd1;
          if (in_last_i) begin
            obuf[n[1:0]] = lead_q;
            n = n + 3'd1;
            if (hcnt_q >= 2'd1) begin
              obuf[n[1:0]] = uds_pkg::rescan(held_q[0], repl_i);
              n = n + 3'd1;
            end
            obuf[n[1:0]] = uds_pkg::rescan(in_byte_i, repl_i);
            n = n + 3'd1;
            lead_d = 8'h00;
            hcnt_d = 2'd0;
            elen_d = 3'd0;
          end
        end
      end else begin
        obuf[n[1:0]] = lead_q;
        n = n + 3'd1;
        if (hcnt_q >= 2'd1) begin
          obuf[n[1:0]] = uds_pkg::rescan(held_q[0], repl_i);
          n = n + 3'd1;
        end
        if (hcnt_q >= 2'd2) begin
          obuf[n[1:0]] = uds_pkg::rescan(held_q[1], repl_i);
          n = n + 3'd1;
        end
        lead_d = 8'h00;
        hcnt_d = 2'd0;
        elen_d = 3'd0;
        fresh  = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (uds_pkg::is_ctrl(in_byte_i)) begin
        obuf[n[1:0]] = repl_i;
        n = n + 3'd1;
      end else if (blen != 3'd0) begin
        if (in_last_i) begin
          obuf[n[1:0]] = in_byte_i;
          n = n + 3'd1;
        end else begin
          lead_d = in_byte_i;
          hcnt_d = 2'd0;
          elen_d = blen;
        end
      end else begin
        obuf[n[1:0]] = uds_pkg::rescan(in_byte_i, repl_i);
        n = n + 3'd1;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < uds_pkg::BundleBytes; k++) bundle_o.data[k] = obuf[k];
    bundle_o.last_idx = 2'(n - 3'd1);
    bundle_o.text_end = in_last_i;
    bundle_vld_o      = accept_i && (n != 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= 8'h00;
      hcnt_q <= 2'd0;
      elen_q <= 3'd0;
    end else if (accept_i) begin
      lead_q <= lead_d;
      hcnt_q <= hcnt_d;
      elen_q <= elen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q[0] <= held_d[0];
      held_q[1] <= held_d[1];
    end
  end

endmodule

@@ design/uds_queue.sv @@
// Two-entry bundle queue between the front end and the back end.
// Depends on uds_pkg for the bundle type and depth.
module uds_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  uds_pkg::bundle_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output uds_pkg::bundle_t head_o,
  output logic             nonempty_o
);

  uds_pkg::bundle_t mem_q [uds_pkg::QueueDepth];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign full_o     = (cnt_q == 2'(uds_pkg::QueueDepth));
  assign nonempty_o = (cnt_q != 2'd0);
  assign head_o     = mem_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ design/uds_back.sv @@
// Back end: takes bundles from the queue and hands them out one byte per
// transfer with the run and text end flags. Depends on uds_pkg.
module uds_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  uds_pkg::bundle_t head_i,
  input  logic             nonempty_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             text_end_o
);

  uds_pkg::bundle_t cur_q;
  logic       vld_q;
  logic [1:0] idx_q;
  logic       fire;
  logic       load;

  assign empty_o    = !vld_q;
  assign out_byte_o = cur_q.data[idx_q];
  assign run_last_o = (idx_q == cur_q.last_idx);
  assign text_end_o = run_last_o && cur_q.text_end;
  assign fire       = pop_i && vld_q;
  assign load       = !vld_q || (fire && run_last_o);
  assign q_pop_o    = load && nonempty_i;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (load) begin
      vld_q <= nonempty_i;
      idx_q <= 2'd0;
    end else if (fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

@@ design/utf8_display_sanitizer.sv @@
// Top level of the UTF-8 display sanitizer: configuration register and the
// front end, bundle queue and back end. Depends on uds_pkg, uds_front, uds_queue, uds_back.
//
//   channel   handshake            payload
//   input     push / full          in_byte_i, in_last_i
//   result    pop / empty          out_byte_o, run_last_o, text_end_o
//   config    psel/penable/pwrite  paddr, pwdata, prdata (replacement byte at 0)
//
// One input byte is taken per cycle while the queue has room; it yields zero to
// four result bytes, delivered one per cycle by the back end while pop is held.
// Sustained rate is one byte per cycle in and out while pop is held; a burst of up
// to four results from one input holds the input off once the two-entry queue fills.
// Reset clears the pending sequence, the queue and the output slot; the
// replacement byte returns to 0x20. No clearing pass is needed.
module utf8_display_sanitizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_last_i,
  input  logic                          pop,
  output logic                          empty,
  output logic [7:0]                    out_byte_o,
  output logic                          run_last_o,
  output logic                          text_end_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uds_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [7:0]       repl_q;
  logic             accept;
  logic             bundle_vld;
  uds_pkg::bundle_t bundle;
  uds_pkg::bundle_t head;
  logic             q_nonempty;
  logic             q_pop;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[uds_pkg::AddrWidth-1] == uds_pkg::RegReplacement);
  assign prdata  = reg_sel ? {24'h000000, repl_q} : 32'h00000000;
  assign accept  = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= uds_pkg::ReplReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      repl_q <= pwdata[7:0];
    end
  end

  uds_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .repl_i       (repl_q),
    .bundle_vld_o (bundle_vld),
    .bundle_o     (bundle)
  );

  uds_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (bundle_vld),
    .push_data_i (bundle),
    .full_o      (full),
    .pop_i       (q_pop),
    .head_o      (head),
    .nonempty_o  (q_nonempty)
  );

  uds_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .nonempty_i (q_nonempty),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o),
    .text_end_o (text_end_o)
  );

endmodule
